/* sv/edge_list_to_adjacency_index_macros.svh */
// assertion macros for the adjacency index builder
`ifndef EDGE_LIST_TO_ADJACENCY_INDEX_MACROS_SVH
`define EDGE_LIST_TO_ADJACENCY_INDEX_MACROS_SVH

`ifndef SYNTHESIS
// implication in the same cycle
`define ELAI_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
// implication in the next cycle
`define ELAI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define ELAI_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define ELAI_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

/* sv/elai_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package elai_pkg;

	localparam int DEF_MAX_ROOMS = 256;
	localparam int DEF_MAX_EDGES = 1024;

	localparam int CMD_W    = 2;
	localparam int ROOM_W   = 8;
	localparam int SLOT_W   = 11;
	localparam int RC_W     = 9;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 12;
	localparam int NUMBER_W = 10;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ROOM_W-1:0] room_first;
		logic [ROOM_W-1:0] room_second;
		logic [ROOM_W-1:0] query_room;
		logic [SLOT_W-1:0] query_slot;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  edge_count;
		logic [NUMBER_W-1:0] edge_number;
		logic                slot_valid;
	} res_t;

endpackage

`default_nettype wire

/* sv/edge_list_to_adjacency_index.sv */
// channel   signals                           beat carries
// in        in_valid / in_ready               cmd, room_first, room_second, query_room, query_slot
// out       out_valid / out_ready             status, edge_count, edge_number, slot_valid
// cfg       cfg_valid / cfg_ready             cfg_data (room_count)
//
// build is carried out by the sequencer walking the edge store, offset, cursor and list
// memories over one shared adder
// in_ready is low while an item is at work or its result waits to enter the output register
// reset clears the control state; the stores are not cleared and need no sweep
`timescale 1ns / 1ps
`default_nettype none
`include "edge_list_to_adjacency_index_macros.svh"

module edge_list_to_adjacency_index
	import elai_pkg::*;
#(
	parameter int MAX_ROOMS = DEF_MAX_ROOMS,
	parameter int MAX_EDGES = DEF_MAX_EDGES
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [RC_W-1:0]     cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire logic [ROOM_W-1:0]   room_first,
	input  wire logic [ROOM_W-1:0]   room_second,
	input  wire logic [ROOM_W-1:0]   query_room,
	input  wire logic [SLOT_W-1:0]   query_slot,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [COUNT_W-1:0]       edge_count,
	output logic [NUMBER_W-1:0]      edge_number,
	output logic                     slot_valid
);

	logic [RC_W-1:0] room_count_q;
	logic            out_valid_q;
	res_t            out_q;
	req_t            req;
	res_t            res;
	logic            seq_idle;
	logic            res_valid;
	logic            res_take;

	assign cfg_ready = 1'b1;
	assign in_ready  = seq_idle;
	assign req       = '{cmd, room_first, room_second, query_room, query_slot};

	// result moves to the output register once that is free
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= '0;
		end else if (cfg_valid) begin
			room_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign edge_count  = out_q.edge_count;
	assign edge_number = out_q.edge_number;
	assign slot_valid  = out_q.slot_valid;

	elai_seq #(.MAX_ROOMS(MAX_ROOMS), .MAX_EDGES(MAX_EDGES)) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.room_count(room_count_q),
		.start(in_valid && in_ready),
		.req(req),
		.idle(seq_idle),
		.res_valid(res_valid),
		.res_take(res_take),
		.res(res)
	);

	`ELAI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ELAI_ASSERT_NEXT(a_result_held, clk, arst_n, res_valid && !res_take, res_valid)
	`ELAI_ASSERT_NOW(a_error_no_list, clk, arst_n, out_valid && (status != ST_OK),
		!slot_valid && (edge_count == '0))
	`ELAI_ASSERT_NOW(a_slot_in_list, clk, arst_n, out_valid && slot_valid, edge_count != '0)

endmodule

`default_nettype wire

/* sv/elai_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module elai_ram
	import elai_pkg::*;
#(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0]   rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/elai_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module elai_seq
	import elai_pkg::*;
#(
	parameter int MAX_ROOMS = DEF_MAX_ROOMS,
	parameter int MAX_EDGES = DEF_MAX_EDGES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [RC_W-1:0] room_count,
	input  wire logic            start,
	input  wire req_t            req,
	output logic                 idle,
	output logic                 res_valid,
	input  wire logic            res_take,
	output res_t                 res
);

	localparam int OFF_DEPTH = ((MAX_ROOMS < 511) ? MAX_ROOMS : 511) + 1;
	localparam int OIW = $clog2(OFF_DEPTH);
	localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ELW = $clog2(MAX_EDGES + 1);
	localparam int LD  = 2 * MAX_EDGES;
	localparam int LIW = $clog2(LD);
	localparam int OW  = $clog2(LD + 1);
	localparam int CW  = (ELW > RC_W + 1) ? ELW : RC_W + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_ADD,
		S_CHK_RD, S_CHK_EV, S_CLR,
		S_CNT_RD, S_CNT_A, S_CNT_AW, S_CNT_B, S_CNT_BW,
		S_PRE_RD, S_PRE_WR,
		S_SC_RD, S_SC_A, S_SC_AW, S_SC_B, S_SC_BW,
		S_FIN,
		S_LK, S_LK_B, S_LK_C, S_LK_D, S_LK_E,
		S_RESP
	} state_t;

	state_t              state_q;
	req_t                req_q;
	res_t                res_q;
	logic [CW-1:0]       idx_q;
	logic [OW-1:0]       acc_q;
	logic [OW-1:0]       base_q;
	logic [OW-1:0]       count_q;
	logic [ROOM_W-1:0]   ea_q;
	logic [ROOM_W-1:0]   eb_q;
	logic [STATUS_W-1:0] err_q;
	logic [ELW-1:0]      edges_q;
	logic [STATUS_W-1:0] lerr_q;
	logic [RC_W-1:0]     pub_q;

	logic [RC_W-1:0]     rooms;
	logic                add_full;
	logic                add_bad;
	logic [STATUS_W-1:0] add_err;
	logic                chk_bad;

	logic                st_we;
	logic [EIW-1:0]      st_waddr;
	logic [15:0]         st_wdata;
	logic [EIW-1:0]      st_raddr;
	logic [15:0]         st_rdata;
	logic                off_we;
	logic [OIW-1:0]      off_waddr;
	logic [OW-1:0]       off_wdata;
	logic [OIW-1:0]      off_raddr;
	logic [OW-1:0]       off_rdata;
	logic                cur_we;
	logic [OIW-1:0]      cur_waddr;
	logic [OW-1:0]       cur_wdata;
	logic [OIW-1:0]      cur_raddr;
	logic [OW-1:0]       cur_rdata;
	logic                lst_we;
	logic [LIW-1:0]      lst_waddr;
	logic [EIW-1:0]      lst_wdata;
	logic [LIW-1:0]      lst_raddr;
	logic [EIW-1:0]      lst_rdata;

	// the one shared adder
	logic [OW-1:0]       alu_a;
	logic [OW-1:0]       alu_b;
	logic                alu_sub;
	logic [OW-1:0]       alu_y;

	assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

	assign rooms = (32'(room_count) > MAX_ROOMS) ? RC_W'(MAX_ROOMS) : room_count;

	assign add_full = 32'(edges_q) >= MAX_EDGES;
	assign add_bad  = (RC_W'(req_q.room_first) >= rooms) || (RC_W'(req_q.room_second) >= rooms);
	always_comb begin
		add_err = lerr_q;
		if (add_full) begin
			add_err = ST_FULL;
		end else if (add_bad && (lerr_q == ST_OK)) begin
			add_err = ST_RANGE;
		end
	end

	assign chk_bad = (RC_W'(st_rdata[7:0]) >= rooms) || (RC_W'(st_rdata[15:8]) >= rooms);

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	always_comb begin
		st_we     = (state_q == S_ADD) && !add_full && !add_bad;
		st_waddr  = edges_q[EIW-1:0];
		st_wdata  = {req_q.room_second, req_q.room_first};
		st_raddr  = idx_q[EIW-1:0];
		off_we    = 1'b0;
		off_waddr = idx_q[OIW-1:0];
		off_wdata = '0;
		off_raddr = idx_q[OIW-1:0];
		cur_we    = 1'b0;
		cur_waddr = idx_q[OIW-1:0];
		cur_wdata = alu_y;
		cur_raddr = OIW'(ea_q);
		lst_we    = 1'b0;
		lst_waddr = cur_rdata[LIW-1:0];
		lst_wdata = idx_q[EIW-1:0];
		lst_raddr = alu_y[LIW-1:0];
		alu_a     = '0;
		alu_b     = '0;
		alu_sub   = 1'b0;
		case (state_q)
			S_CLR: begin
				off_we = 1'b1;
			end
			S_CNT_A: begin
				off_raddr = OIW'(RC_W'(st_rdata[7:0]) + RC_W'(1));
			end
			S_CNT_AW: begin
				alu_a     = off_rdata;
				alu_b     = OW'(1);
				off_we    = 1'b1;
				off_waddr = OIW'(RC_W'(ea_q) + RC_W'(1));
				off_wdata = alu_y;
			end
			S_CNT_B: begin
				off_raddr = OIW'(RC_W'(eb_q) + RC_W'(1));
			end
			S_CNT_BW: begin
				alu_a     = off_rdata;
				alu_b     = OW'(1);
				off_we    = 1'b1;
				off_waddr = OIW'(RC_W'(eb_q) + RC_W'(1));
				off_wdata = alu_y;
			end
			S_PRE_WR: begin
				alu_a     = acc_q;
				alu_b     = off_rdata;
				off_we    = 1'b1;
				off_wdata = alu_y;
				cur_we    = 1'b1;
			end
			S_SC_A: begin
				cur_raddr = OIW'(st_rdata[7:0]);
			end
			S_SC_AW: begin
				alu_a     = cur_rdata;
				alu_b     = OW'(1);
				lst_we    = 1'b1;
				cur_we    = 1'b1;
				cur_waddr = OIW'(ea_q);
			end
			S_SC_B: begin
				cur_raddr = OIW'(eb_q);
			end
			S_SC_BW: begin
				alu_a     = cur_rdata;
				alu_b     = OW'(1);
				lst_we    = 1'b1;
				cur_we    = 1'b1;
				cur_waddr = OIW'(eb_q);
			end
			S_LK: begin
				off_raddr = OIW'(req_q.query_room);
			end
			S_LK_B: begin
				off_raddr = OIW'(RC_W'(req_q.query_room) + RC_W'(1));
			end
			S_LK_C: begin
				alu_a   = off_rdata;
				alu_b   = base_q;
				alu_sub = 1'b1;
			end
			S_LK_D: begin
				alu_a = base_q;
				alu_b = OW'(req_q.query_slot);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= '0;
			res_q   <= '0;
			idx_q   <= '0;
			acc_q   <= '0;
			base_q  <= '0;
			count_q <= '0;
			ea_q    <= '0;
			eb_q    <= '0;
			err_q   <= ST_OK;
			edges_q <= '0;
			lerr_q  <= ST_OK;
			pub_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						res_q <= '0;
						idx_q <= '0;
						err_q <= lerr_q;
						case (req.cmd)
							CMD_ADD:    state_q <= S_ADD;
							CMD_BUILD:  state_q <= (lerr_q != ST_OK) ? S_FIN : S_CHK_RD;
							CMD_LOOKUP: state_q <= S_LK;
							default:    state_q <= S_RESP;
						endcase
					end
				end
				S_ADD: begin
					lerr_q       <= add_err;
					res_q.status <= add_err;
					if (!add_full && !add_bad) begin
						edges_q <= edges_q + ELW'(1);
					end
					state_q <= S_RESP;
				end
				S_CHK_RD: begin
					if (idx_q >= CW'(edges_q)) begin
						idx_q   <= '0;
						state_q <= S_CLR;
					end else begin
						state_q <= S_CHK_EV;
					end
				end
				S_CHK_EV: begin
					if (chk_bad) begin
						err_q   <= ST_RANGE;
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_CHK_RD;
					end
				end
				S_CLR: begin
					if (idx_q == CW'(rooms)) begin
						idx_q   <= '0;
						state_q <= S_CNT_RD;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_CNT_RD: begin
					if (idx_q >= CW'(edges_q)) begin
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_PRE_RD;
					end else begin
						state_q <= S_CNT_A;
					end
				end
				S_CNT_A: begin
					ea_q    <= st_rdata[7:0];
					eb_q    <= st_rdata[15:8];
					state_q <= S_CNT_AW;
				end
				S_CNT_AW: state_q <= S_CNT_B;
				S_CNT_B:  state_q <= S_CNT_BW;
				S_CNT_BW: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_CNT_RD;
				end
				S_PRE_RD: begin
					if (idx_q > CW'(rooms)) begin
						idx_q   <= '0;
						state_q <= S_SC_RD;
					end else begin
						state_q <= S_PRE_WR;
					end
				end
				S_PRE_WR: begin
					acc_q   <= alu_y;
					idx_q   <= idx_q + CW'(1);
					state_q <= S_PRE_RD;
				end
				S_SC_RD: begin
					if (idx_q >= CW'(edges_q)) begin
						pub_q   <= rooms;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SC_A;
					end
				end
				S_SC_A: begin
					ea_q    <= st_rdata[7:0];
					eb_q    <= st_rdata[15:8];
					state_q <= S_SC_AW;
				end
				S_SC_AW: state_q <= S_SC_B;
				S_SC_B:  state_q <= S_SC_BW;
				S_SC_BW: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_SC_RD;
				end
				S_FIN: begin
					edges_q      <= '0;
					lerr_q       <= ST_OK;
					res_q.status <= err_q;
					state_q      <= S_RESP;
				end
				S_LK: begin
					state_q <= (RC_W'(req_q.query_room) >= pub_q) ? S_RESP : S_LK_B;
				end
				S_LK_B: begin
					base_q  <= off_rdata;
					state_q <= S_LK_C;
				end
				S_LK_C: begin
					count_q          <= alu_y;
					res_q.edge_count <= COUNT_W'(alu_y);
					state_q          <= S_LK_D;
				end
				S_LK_D: begin
					if (32'(req_q.query_slot) < 32'(count_q)) begin
						res_q.slot_valid <= 1'b1;
						state_q          <= S_LK_E;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_LK_E: begin
					res_q.edge_number <= NUMBER_W'(lst_rdata);
					state_q           <= S_RESP;
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	elai_ram #(.DEPTH(MAX_EDGES), .WIDTH(16)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	elai_ram #(.DEPTH(OFF_DEPTH), .WIDTH(OW)) u_offsets (
		.clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
		.raddr(off_raddr), .rdata(off_rdata)
	);

	elai_ram #(.DEPTH(OFF_DEPTH), .WIDTH(OW)) u_cursors (
		.clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
		.raddr(cur_raddr), .rdata(cur_rdata)
	);

	elai_ram #(.DEPTH(LD), .WIDTH(EIW)) u_list (
		.clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
		.raddr(lst_raddr), .rdata(lst_rdata)
	);

endmodule

`default_nettype wire

/* dv/edge_list_to_adjacency_index_tb.sv */
`timescale 1ns / 1ps

module edge_list_to_adjacency_index_tb;
	import elai_pkg::*;

	localparam int ROOMS_MAX   = 256;
	localparam int EDGES_MAX   = 1024;
	localparam int CYCLE_LIMIT = 1000000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [RC_W-1:0]     cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    cmd = CMD_ADD;
	logic [ROOM_W-1:0]   room_first = '0;
	logic [ROOM_W-1:0]   room_second = '0;
	logic [ROOM_W-1:0]   query_room = '0;
	logic [SLOT_W-1:0]   query_slot = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  edge_count;
	logic [NUMBER_W-1:0] edge_number;
	logic                slot_valid;

	edge_list_to_adjacency_index u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .room_first(room_first), .room_second(room_second),
		.query_room(query_room), .query_slot(query_slot),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .edge_count(edge_count),
		.edge_number(edge_number), .slot_valid(slot_valid)
	);

	always #5 clk = ~clk;

	// shadow of the block
	logic [15:0]         pairs_mem [EDGES_MAX];
	int                  pairs_loaded;
	logic [STATUS_W-1:0] latched_err;
	int                  room_start [ROOMS_MAX+1];
	logic [NUMBER_W-1:0] room_lists [2*EDGES_MAX];
	int                  index_rooms;
	int                  room_count_reg;

	res_t adjacency_expected [$];
	int   fail_count;
	int   beats_sent;
	int   beats_checked;
	int   builds_sent;
	int   cycle_count;
	int   send_idle_pct = 20;
	int   recv_stall_pct = 20;

	function automatic res_t predict_adjacency(req_t q);
		res_t r;
		int rooms;
		logic [STATUS_W-1:0] err;
		int a;
		int b;
		int base;
		int cnt;
		int cursor [ROOMS_MAX+1];
		r = '0;
		rooms = (room_count_reg > ROOMS_MAX) ? ROOMS_MAX : room_count_reg;
		case (q.cmd)
			CMD_ADD: begin
				if (pairs_loaded >= EDGES_MAX) begin
					latched_err = ST_FULL;
				end else if (q.room_first >= rooms || q.room_second >= rooms) begin
					if (latched_err == ST_OK)
						latched_err = ST_RANGE;
				end else begin
					pairs_mem[pairs_loaded] = {q.room_second, q.room_first};
					pairs_loaded++;
				end
				r.status = latched_err;
			end
			CMD_BUILD: begin
				err = latched_err;
				if (err == ST_OK) begin
					for (int i = 0; i < pairs_loaded; i++) begin
						if (pairs_mem[i][7:0] >= rooms || pairs_mem[i][15:8] >= rooms) begin
							err = ST_RANGE;
							break;
						end
					end
				end
				if (err == ST_OK) begin
					for (int i = 0; i <= rooms; i++)
						room_start[i] = 0;
					for (int i = 0; i < pairs_loaded; i++) begin
						room_start[pairs_mem[i][7:0] + 1]++;
						room_start[pairs_mem[i][15:8] + 1]++;
					end
					for (int i = 1; i <= rooms; i++)
						room_start[i] += room_start[i-1];
					for (int i = 0; i <= rooms; i++)
						cursor[i] = room_start[i];
					for (int i = 0; i < pairs_loaded; i++) begin
						a = pairs_mem[i][7:0];
						b = pairs_mem[i][15:8];
						room_lists[cursor[a]] = NUMBER_W'(i);
						cursor[a]++;
						room_lists[cursor[b]] = NUMBER_W'(i);
						cursor[b]++;
					end
					index_rooms = rooms;
				end
				pairs_loaded = 0;
				latched_err = ST_OK;
				r.status = err;
			end
			CMD_LOOKUP: begin
				if (q.query_room < index_rooms) begin
					base = room_start[q.query_room];
					cnt = room_start[q.query_room + 1] - base;
					r.edge_count = COUNT_W'(cnt);
					if (q.query_slot < cnt) begin
						r.slot_valid = 1'b1;
						r.edge_number = room_lists[base + q.query_slot];
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: random stall and in-order compare
	always @(posedge clk) begin
		res_t e;
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			if (adjacency_expected.size() == 0) begin
				$error("unexpected result beat");
				fail_count++;
			end else begin
				e = adjacency_expected.pop_front();
				beats_checked++;
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status);
					fail_count++;
				end
				if (edge_count !== e.edge_count) begin
					$error("edge_count exp %0d got %0d", e.edge_count, edge_count);
					fail_count++;
				end
				if (edge_number !== e.edge_number) begin
					$error("edge_number exp %0d got %0d", e.edge_number, edge_number);
					fail_count++;
				end
				if (slot_valid !== e.slot_valid) begin
					$error("slot_valid exp %0d got %0d", e.slot_valid, slot_valid);
					fail_count++;
				end
			end
		end
	end

	task automatic send_beat(logic [CMD_W-1:0] c, int a, int b, int qr, int qs);
		req_t q;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		q.cmd = c;
		q.room_first = ROOM_W'(a);
		q.room_second = ROOM_W'(b);
		q.query_room = ROOM_W'(qr);
		q.query_slot = SLOT_W'(qs);
		in_valid <= 1'b1;
		cmd <= q.cmd;
		room_first <= q.room_first;
		room_second <= q.room_second;
		query_room <= q.query_room;
		query_slot <= q.query_slot;
		do @(posedge clk); while (!in_ready);
		adjacency_expected.push_back(predict_adjacency(q));
		beats_sent++;
		if (c == CMD_BUILD)
			builds_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (adjacency_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_room_count(int v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= RC_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		room_count_reg = v;
	endtask

	function automatic int eff_rooms();
		return (room_count_reg > ROOMS_MAX) ? ROOMS_MAX : room_count_reg;
	endfunction

	task automatic test_directed();
		write_room_count(256);
		send_beat(CMD_LOOKUP, 0, 0, 0, 0);
		send_beat(CMD_ADD, 0, 0, 0, 0);
		send_beat(CMD_ADD, 255, 255, 0, 0);
		send_beat(CMD_ADD, 0, 255, 0, 0);
		send_beat(CMD_ADD, 8'haa, 8'h55, 0, 0);
		send_beat(CMD_BUILD, 0, 0, 0, 0);
		for (int s = 0; s < 4; s++)
			send_beat(CMD_LOOKUP, 0, 0, 0, s);
		send_beat(CMD_LOOKUP, 0, 0, 255, 2);
		send_beat(CMD_LOOKUP, 0, 0, 255, 2047);
		send_beat(CMD_UNUSED, 255, 255, 255, 2047);
		// failed build keeps the old index
		write_room_count(4);
		send_beat(CMD_ADD, 5, 1, 0, 0);
		send_beat(CMD_ADD, 1, 2, 0, 0);
		send_beat(CMD_BUILD, 0, 0, 0, 0);
		send_beat(CMD_LOOKUP, 0, 0, 0, 1);
		// endpoint no longer in range at build time
		send_beat(CMD_ADD, 3, 3, 0, 0);
		write_room_count(2);
		send_beat(CMD_BUILD, 0, 0, 0, 0);
		send_beat(CMD_LOOKUP, 0, 0, 8'haa, 0);
		write_room_count(0);
		send_beat(CMD_ADD, 0, 0, 0, 0);
		send_beat(CMD_BUILD, 0, 0, 0, 0);
		send_beat(CMD_BUILD, 0, 0, 0, 0);
		send_beat(CMD_LOOKUP, 0, 0, 0, 0);
	endtask

	task automatic test_store_full();
		write_room_count(200);
		send_beat(CMD_ADD, 250, 1, 0, 0);
		for (int i = 0; i < EDGES_MAX + 1; i++)
			send_beat(CMD_ADD, $urandom_range(199), $urandom_range(199), 0, 0);
		send_beat(CMD_BUILD, 0, 0, 0, 0);
		// the index from before the failed build must still answer
		for (int i = 0; i < 20; i++)
			send_beat(CMD_LOOKUP, 0, 0, $urandom_range(255), $urandom_range(20));
	endtask

	function automatic int pick_room_count();
		case ($urandom_range(5))
			0: return 0;
			1: return 1;
			2: return 256;
			3: return 511;
			default: return $urandom_range(2, 256);
		endcase
	endfunction

	task automatic run_random(int idle_in, int stall_out, int n_items);
		int stop_at;
		int rooms;
		int deg;
		send_idle_pct = idle_in;
		recv_stall_pct = stall_out;
		stop_at = beats_sent + n_items;
		while (beats_sent < stop_at) begin
			write_room_count(pick_room_count());
			rooms = eff_rooms();
			repeat ($urandom_range(2, 5)) begin
				repeat ($urandom_range(1, 24)) begin
					if (rooms > 0 && $urandom_range(9) != 0)
						send_beat(CMD_ADD, $urandom_range(rooms-1), $urandom_range(rooms-1),
							$urandom_range(255), $urandom_range(2047));
					else
						send_beat(CMD_ADD, $urandom_range(255), $urandom_range(255),
							$urandom_range(255), $urandom_range(2047));
				end
				if ($urandom_range(9) == 0)
					send_beat(CMD_UNUSED, $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(2047));
				send_beat(CMD_BUILD, $urandom_range(255), $urandom_range(255),
					$urandom_range(255), $urandom_range(2047));
				repeat ($urandom_range(2, 12)) begin
					if ($urandom_range(9) == 0) begin
						send_beat(CMD_LOOKUP, $urandom_range(255), $urandom_range(255),
							$urandom_range(255), $urandom_range(2047));
					end else begin
						deg = (index_rooms > 0) ? $urandom_range(index_rooms) : $urandom_range(3);
						send_beat(CMD_LOOKUP, 0, 0, deg, $urandom_range(6));
					end
				end
			end
		end
	endtask

	initial begin
		fail_count = 0;
		beats_sent = 0;
		beats_checked = 0;
		builds_sent = 0;
		cycle_count = 0;
		pairs_loaded = 0;
		latched_err = ST_OK;
		index_rooms = 0;
		room_count_reg = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		run_random(37, 86, 50);
		run_random(86, 37, 50);
		run_random(0, 0, 50);
		test_store_full();
		wait_drained();
		repeat (50) @(posedge clk);
		$display("covered %0d input beats, %0d builds, %0d results checked",
			beats_sent, builds_sent, beats_checked);
		$display("room counts from 0 to 511, full store, failed builds and lookups past the end");
		if (fail_count == 0 && adjacency_expected.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
